// ===== hw/rtl/dcs_pkg.sv =====
// Shared constants, codes and types of the distance constraint solver.
// No dependencies; used by the interfaces, the arithmetic unit, the top level, the checker and the testbench.

package dcs_pkg;

	// Particle store
	localparam int PARTICLES = 1024;
	localparam int ADDR_W    = (PARTICLES > 1) ? $clog2(PARTICLES) : 1;

	// Field widths
	localparam int IDX_W     = 10;
	localparam int POS_W     = 32;
	localparam int MASS_W    = 32;
	localparam int FRC_W     = 48;
	localparam int REST_W    = 31;
	localparam int CFG_W     = 48;
	localparam int CFG_IDX_W = 2;

	// Arithmetic unit widths
	localparam int MUL_A_W = 51;
	localparam int MUL_B_W = 48;
	localparam int PROD_W  = MUL_A_W + MUL_B_W;
	localparam int DIV_N_W = 50;
	localparam int DIV_D_W = 34;
	localparam int ROOT_W  = 34;
	localparam int RAD_W   = 2 * ROOT_W;
	localparam int ARG_W   = RAD_W;
	localparam int CNT_W   = 6;

	// Magnitude limits of the scaled products
	localparam logic [46:0] T_LIM = 47'h4000_0000_0000;
	localparam logic [46:0] F_LIM = 47'h7FFF_FFFF_FFFF;

	localparam logic [CFG_W-1:0] INV_DT_SQ_RST = 48'd65536;

	// Register indexes
	localparam logic [CFG_IDX_W-1:0] REG_STRETCH_ALPHA = 2'd0;
	localparam logic [CFG_IDX_W-1:0] REG_BEND_ALPHA    = 2'd1;
	localparam logic [CFG_IDX_W-1:0] REG_INV_DT_SQ     = 2'd2;

	typedef enum logic [1:0] {
		FN_WRITE = 2'd0,
		FN_SOLVE = 2'd1,
		FN_READ  = 2'd2,
		FN_CLEAR = 2'd3
	} func_t;

	typedef enum logic [1:0] {
		STS_READ    = 2'd0,
		STS_APPLIED = 2'd1,
		STS_SKIPPED = 2'd2
	} status_t;

	typedef enum logic [1:0] {
		AOP_MUL  = 2'd0,
		AOP_DIV  = 2'd1,
		AOP_SQRT = 2'd2
	} arith_op_t;

	typedef struct packed {
		logic            start;
		arith_op_t       op;
		logic [ARG_W-1:0] opa;
		logic [MUL_B_W-1:0] opb;
	} arith_req_t;

	typedef struct packed {
		logic              done;
		logic [PROD_W-1:0] res;
	} arith_rsp_t;

	typedef struct packed {
		logic [2:0][POS_W-1:0] pos;
		logic [MASS_W-1:0]     inv_mass;
	} part_t;

	typedef logic [2:0][FRC_W-1:0] frc_t;

endpackage

// ===== hw/rtl/dcs_if.sv =====
// Command and response channel interfaces of the distance constraint solver.
// Depends on dcs_pkg for field widths.

interface dcs_cmd_if;
	logic                               valid;
	logic                               ready;
	logic [1:0]                         func;
	logic                               kind;
	logic [dcs_pkg::IDX_W-1:0]          particle_a;
	logic [dcs_pkg::IDX_W-1:0]          particle_b;
	logic [dcs_pkg::REST_W-1:0]         rest_length;
	logic signed [dcs_pkg::POS_W-1:0]   pos_x;
	logic signed [dcs_pkg::POS_W-1:0]   pos_y;
	logic signed [dcs_pkg::POS_W-1:0]   pos_z;
	logic [dcs_pkg::MASS_W-1:0]         inv_mass;

	modport source (output valid, func, kind, particle_a, particle_b, rest_length,
		pos_x, pos_y, pos_z, inv_mass, input ready);
	modport sink (input valid, func, kind, particle_a, particle_b, rest_length,
		pos_x, pos_y, pos_z, inv_mass, output ready);
endinterface

interface dcs_rsp_if;
	logic                               valid;
	logic                               ready;
	logic [1:0]                         status;
	logic signed [dcs_pkg::POS_W-1:0]   out_pos_x;
	logic signed [dcs_pkg::POS_W-1:0]   out_pos_y;
	logic signed [dcs_pkg::POS_W-1:0]   out_pos_z;
	logic signed [dcs_pkg::FRC_W-1:0]   out_force_x;
	logic signed [dcs_pkg::FRC_W-1:0]   out_force_y;
	logic signed [dcs_pkg::FRC_W-1:0]   out_force_z;
	logic [dcs_pkg::MASS_W-1:0]         out_inv_mass;

	modport source (output valid, status, out_pos_x, out_pos_y, out_pos_z,
		out_force_x, out_force_y, out_force_z, out_inv_mass, input ready);
	modport sink (input valid, status, out_pos_x, out_pos_y, out_pos_z,
		out_force_x, out_force_y, out_force_z, out_inv_mass, output ready);
endinterface

// ===== hw/rtl/dcs_arith.sv =====
// Shared iterative arithmetic unit: shift-add multiply, restoring divide, integer square root.
// Depends on dcs_pkg for the request and response types.

module dcs_arith (
	input  logic                clk,
	input  logic                arst_n,
	input  dcs_pkg::arith_req_t req,
	output dcs_pkg::arith_rsp_t rsp
);

	logic                        busy_q;
	dcs_pkg::arith_op_t          op_q;
	logic [dcs_pkg::CNT_W-1:0]   cnt_q;

	// multiplier state
	logic [dcs_pkg::PROD_W-1:0]  mx_q;
	logic [dcs_pkg::MUL_B_W-1:0] my_q;
	logic [dcs_pkg::PROD_W-1:0]  macc_q;

	// divider state
	logic [dcs_pkg::DIV_N_W-1:0] dn_q;
	logic [dcs_pkg::DIV_D_W-1:0] dd_q;
	logic [dcs_pkg::DIV_D_W-1:0] drem_q;

	// square root state
	logic [dcs_pkg::RAD_W-1:0]   sr_q;
	logic [dcs_pkg::ROOT_W-1:0]  root_q;
	logic [dcs_pkg::ROOT_W:0]    srem_q;

	logic [dcs_pkg::DIV_D_W:0]   d_sh;
	logic                        d_ge;
	logic [dcs_pkg::ROOT_W+2:0]  s_sh;
	logic [dcs_pkg::ROOT_W+2:0]  s_trial;
	logic                        s_ge;
	logic                        done;

	// One divide and one root step from the current remainders
	always_comb begin
		d_sh    = {drem_q, dn_q[dcs_pkg::DIV_N_W-1]};
		d_ge    = d_sh >= {1'b0, dd_q};
		s_sh    = {srem_q, sr_q[dcs_pkg::RAD_W-1 -: 2]};
		s_trial = {1'b0, root_q, 2'b01};
		s_ge    = s_sh >= s_trial;
	end

	always_comb begin
		case (op_q)
			dcs_pkg::AOP_MUL: done = busy_q && (my_q == '0);
			default:          done = busy_q && (cnt_q == '0);
		endcase
	end

	assign rsp.done = done;

	always_comb begin
		case (op_q)
			dcs_pkg::AOP_MUL:  rsp.res = macc_q;
			dcs_pkg::AOP_DIV:  rsp.res = dcs_pkg::PROD_W'(dn_q);
			dcs_pkg::AOP_SQRT: rsp.res = dcs_pkg::PROD_W'(root_q);
			default:           rsp.res = macc_q;
		endcase
	end

	// Control: launch on start, drop busy once the result is shown
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			busy_q <= 1'b0;
			op_q   <= dcs_pkg::AOP_MUL;
			cnt_q  <= '0;
		end else if (req.start) begin
			busy_q <= 1'b1;
			op_q   <= req.op;
			case (req.op)
				dcs_pkg::AOP_DIV:  cnt_q <= dcs_pkg::CNT_W'(dcs_pkg::DIV_N_W);
				dcs_pkg::AOP_SQRT: cnt_q <= dcs_pkg::CNT_W'(dcs_pkg::ROOT_W);
				default:           cnt_q <= '0;
			endcase
		end else if (done) begin
			busy_q <= 1'b0;
		end else if (busy_q && cnt_q != '0) begin
			cnt_q <= cnt_q - 1'b1;
		end
	end

	// Datapath: load operands, then one bit (or one root digit) per cycle
	always_ff @(posedge clk) begin
		if (req.start) begin
			mx_q   <= dcs_pkg::PROD_W'(req.opa[dcs_pkg::MUL_A_W-1:0]);
			my_q   <= req.opb;
			macc_q <= '0;
			dn_q   <= req.opa[dcs_pkg::DIV_N_W-1:0];
			dd_q   <= req.opb[dcs_pkg::DIV_D_W-1:0];
			drem_q <= '0;
			sr_q   <= req.opa;
			root_q <= '0;
			srem_q <= '0;
		end else if (busy_q && !done) begin
			case (op_q)
				dcs_pkg::AOP_MUL: begin
					if (my_q[0]) begin
						macc_q <= macc_q + mx_q;
					end
					mx_q <= {mx_q[dcs_pkg::PROD_W-2:0], 1'b0};
					my_q <= {1'b0, my_q[dcs_pkg::MUL_B_W-1:1]};
				end
				dcs_pkg::AOP_DIV: begin
					drem_q <= d_ge ? dcs_pkg::DIV_D_W'(d_sh - {1'b0, dd_q})
						: d_sh[dcs_pkg::DIV_D_W-1:0];
					dn_q   <= {dn_q[dcs_pkg::DIV_N_W-2:0], d_ge};
				end
				dcs_pkg::AOP_SQRT: begin
					srem_q <= s_ge ? (dcs_pkg::ROOT_W+1)'(s_sh - s_trial)
						: s_sh[dcs_pkg::ROOT_W:0];
					root_q <= {root_q[dcs_pkg::ROOT_W-2:0], s_ge};
					sr_q   <= {sr_q[dcs_pkg::RAD_W-3:0], 2'b00};
				end
				default: begin
					macc_q <= macc_q;
				end
			endcase
		end
	end

endmodule

// ===== hw/rtl/distance_constraint_solver_top.sv =====
// Distance constraint solver top level: particle store, force store, sequencer.
// Depends on dcs_pkg, the dcs_cmd_if / dcs_rsp_if interfaces and dcs_arith.
//
//  channel  | direction | handshake      | carries
//  ---------+-----------+----------------+------------------------------------------
//  cmd      | in        | valid / ready  | func, kind, particles, rest length, write data
//  rsp      | out       | valid / ready  | status, position, force, inverse mass
//  cfg      | in        | cfg_wr_en only | register index and write data
//
// An applied solve runs three squares, one root (34 steps), four divides (50 steps each)
// and up to twelve further shift-add multiplies, one after another on the one shared unit.
// After reset the whole force store is zeroed before cmd.ready rises.
// A new item is taken while the previous result still waits on a stalled rsp.

module distance_constraint_solver_top (
	input  logic                            clk,
	input  logic                            arst_n,
	dcs_cmd_if.sink                         cmd,
	dcs_rsp_if.source                       rsp,
	input  logic                            cfg_wr_en,
	input  logic [dcs_pkg::CFG_IDX_W-1:0]   cfg_index,
	input  logic [dcs_pkg::CFG_W-1:0]       cfg_wdata
);

	typedef enum logic [23:0] {
		S_CLEAR     = 24'h000001,
		S_IDLE      = 24'h000002,
		S_WRITE     = 24'h000004,
		S_RD_A      = 24'h000008,
		S_RD_CAP    = 24'h000010,
		S_LD_A      = 24'h000020,
		S_LD_B      = 24'h000040,
		S_CHK       = 24'h000080,
		S_DIFF      = 24'h000100,
		S_SQ_GO     = 24'h000200,
		S_SQ_WAIT   = 24'h000400,
		S_SQRT_GO   = 24'h000800,
		S_SQRT_WAIT = 24'h001000,
		S_G_GO      = 24'h002000,
		S_G_WAIT    = 24'h004000,
		S_LM_GO     = 24'h008000,
		S_LM_WAIT   = 24'h010000,
		S_T_GO      = 24'h020000,
		S_T_WAIT    = 24'h040000,
		S_S_GO      = 24'h080000,
		S_S_WAIT    = 24'h100000,
		S_WB_A      = 24'h200000,
		S_WB_B      = 24'h400000,
		S_OUT       = 24'h800000
	} state_t;

	localparam int AW = dcs_pkg::ADDR_W;

	state_t state_q;

	// configuration
	logic [31:0]                   stretch_alpha_q;
	logic [31:0]                   bend_alpha_q;
	logic [dcs_pkg::CFG_W-1:0]     inv_dt_sq_q;

	// item registers
	dcs_pkg::func_t                func_q;
	logic                          kind_q;
	logic [AW-1:0]                 a_q;
	logic [AW-1:0]                 b_q;
	logic                          a_ok_q;
	logic [dcs_pkg::REST_W-1:0]    rest_q;
	dcs_pkg::part_t                wdat_q;
	logic [AW-1:0]                 clr_cnt_q;

	// stores
	dcs_pkg::part_t                pos_mem [dcs_pkg::PARTICLES];
	dcs_pkg::frc_t                 frc_mem [dcs_pkg::PARTICLES];
	dcs_pkg::part_t                pos_rd_q;
	dcs_pkg::frc_t                 frc_rd_q;
	logic                          pos_we;
	logic [AW-1:0]                 pos_waddr;
	dcs_pkg::part_t                pos_wdata;
	logic                          frc_we;
	logic [AW-1:0]                 frc_waddr;
	dcs_pkg::frc_t                 frc_wdata;
	logic [AW-1:0]                 rd_addr;

	// solve working registers
	dcs_pkg::part_t                pa_q;
	dcs_pkg::part_t                pb_q;
	dcs_pkg::frc_t                 fa_q;
	dcs_pkg::frc_t                 fb_q;
	logic [2:0][32:0]              dmag_q;
	logic [2:0]                    dneg_q;
	logic [65:0]                   sum_q;
	logic [dcs_pkg::ROOT_W-1:0]    len_q;
	logic [2:0][16:0]              gmag_q;
	logic [2:0]                    gneg_q;
	logic [dcs_pkg::MUL_A_W-1:0]   lm_q;
	logic                          lam_neg_q;
	logic [2:0][46:0]              tmag_q;
	logic [1:0]                    ax_q;
	logic [1:0]                    term_q;
	dcs_pkg::status_t              pend_status_q;

	// output register
	logic                          ovalid_q;
	logic [1:0]                    ostatus_q;
	dcs_pkg::part_t                opart_q;
	dcs_pkg::frc_t                 ofrc_q;

	dcs_pkg::arith_req_t           areq;
	dcs_pkg::arith_rsp_t           arsp;

	logic                          accept;
	logic                          a_in_ok;
	logic                          b_in_ok;
	logic                          out_free;
	logic [34:0]                   c_w;
	logic [33:0]                   c_mag;
	logic [33:0]                   k_w;
	logic [82:0]                   t_raw;
	logic [46:0]                   t_lim;
	logic [46:0]                   step;
	logic signed [47:0]            sstep;
	logic signed [47:0]            pos_sum;
	logic signed [48:0]            frc_sum_a;
	logic signed [48:0]            frc_sum_b;

	function automatic logic [31:0] sat32(input logic signed [47:0] v);
		if (v > 48'sh0000_7FFF_FFFF) begin
			sat32 = 32'h7FFF_FFFF;
		end else if (v < -48'sh0000_8000_0000) begin
			sat32 = 32'h8000_0000;
		end else begin
			sat32 = v[31:0];
		end
	endfunction

	function automatic logic [47:0] sat48(input logic signed [48:0] v);
		if (v > 49'sh0_7FFF_FFFF_FFFF) begin
			sat48 = 48'h7FFF_FFFF_FFFF;
		end else if (v < -49'sh0_8000_0000_0000) begin
			sat48 = 48'h8000_0000_0000;
		end else begin
			sat48 = v[47:0];
		end
	endfunction

	assign cmd.ready = (state_q == S_IDLE);
	assign accept    = cmd.valid && cmd.ready;
	assign a_in_ok   = 32'(cmd.particle_a) < dcs_pkg::PARTICLES;
	assign b_in_ok   = 32'(cmd.particle_b) < dcs_pkg::PARTICLES;
	assign out_free  = !ovalid_q || rsp.ready;

	assign rsp.valid        = ovalid_q;
	assign rsp.status       = ostatus_q;
	assign rsp.out_pos_x    = opart_q.pos[0];
	assign rsp.out_pos_y    = opart_q.pos[1];
	assign rsp.out_pos_z    = opart_q.pos[2];
	assign rsp.out_force_x  = ofrc_q[0];
	assign rsp.out_force_y  = ofrc_q[1];
	assign rsp.out_force_z  = ofrc_q[2];
	assign rsp.out_inv_mass = opart_q.inv_mass;

	// Configuration writes
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			stretch_alpha_q <= '0;
			bend_alpha_q    <= '0;
			inv_dt_sq_q     <= dcs_pkg::INV_DT_SQ_RST;
		end else if (cfg_wr_en) begin
			case (cfg_index)
				dcs_pkg::REG_STRETCH_ALPHA: stretch_alpha_q <= cfg_wdata[31:0];
				dcs_pkg::REG_BEND_ALPHA:    bend_alpha_q    <= cfg_wdata[31:0];
				dcs_pkg::REG_INV_DT_SQ:     inv_dt_sq_q     <= cfg_wdata;
				default:                    inv_dt_sq_q     <= inv_dt_sq_q;
			endcase
		end
	end

	// Store ports
	always_comb begin
		pos_we    = 1'b0;
		pos_waddr = a_q;
		pos_wdata = pa_q;
		frc_we    = 1'b0;
		frc_waddr = a_q;
		frc_wdata = fa_q;
		rd_addr   = (state_q == S_LD_B) ? b_q : a_q;
		case (state_q)
			S_WRITE: begin
				pos_we    = a_ok_q;
				pos_wdata = wdat_q;
			end
			S_CLEAR: begin
				frc_we    = 1'b1;
				frc_waddr = clr_cnt_q;
				frc_wdata = '0;
			end
			S_WB_A: begin
				pos_we = 1'b1;
				frc_we = 1'b1;
			end
			S_WB_B: begin
				pos_we    = 1'b1;
				pos_waddr = b_q;
				pos_wdata = pb_q;
				frc_we    = 1'b1;
				frc_waddr = b_q;
				frc_wdata = fb_q;
			end
			default: begin
				pos_we = 1'b0;
			end
		endcase
	end

	always_ff @(posedge clk) begin
		if (pos_we) begin
			pos_mem[pos_waddr] <= pos_wdata;
		end
		pos_rd_q <= pos_mem[rd_addr];
	end

	always_ff @(posedge clk) begin
		if (frc_we) begin
			frc_mem[frc_waddr] <= frc_wdata;
		end
		frc_rd_q <= frc_mem[rd_addr];
	end

	// Constraint error, lambda denominator and scaled-product limit
	always_comb begin
		c_w   = {1'b0, len_q} - {4'b0, rest_q};
		c_mag = c_w[34] ? 34'(-c_w) : c_w[33:0];
		k_w   = 34'(pa_q.inv_mass) + 34'(pb_q.inv_mass)
			+ 34'(kind_q ? bend_alpha_q : stretch_alpha_q);
		t_raw = arsp.res[98:16];
		t_lim = (term_q == 2'd2) ? dcs_pkg::F_LIM : dcs_pkg::T_LIM;
	end

	// Correction step of one axis and its application
	always_comb begin
		step      = arsp.res[62:16];
		sstep     = (lam_neg_q ^ gneg_q[ax_q]) ? -$signed({1'b0, step}) : $signed({1'b0, step});
		case (term_q)
			2'd0:    pos_sum = $signed({{16{pa_q.pos[ax_q][31]}}, pa_q.pos[ax_q]}) + sstep;
			default: pos_sum = $signed({{16{pb_q.pos[ax_q][31]}}, pb_q.pos[ax_q]}) - sstep;
		endcase
		frc_sum_a = $signed({fa_q[ax_q][47], fa_q[ax_q]}) + $signed({sstep[47], sstep});
		frc_sum_b = $signed({fb_q[ax_q][47], fb_q[ax_q]}) - $signed({sstep[47], sstep});
	end

	// Requests to the shared unit
	always_comb begin
		areq = '0;
		case (state_q)
			S_SQ_GO: begin
				areq.start = 1'b1;
				areq.op    = dcs_pkg::AOP_MUL;
				areq.opa   = dcs_pkg::ARG_W'(dmag_q[ax_q]);
				areq.opb   = dcs_pkg::MUL_B_W'(dmag_q[ax_q]);
			end
			S_SQRT_GO: begin
				areq.start = 1'b1;
				areq.op    = dcs_pkg::AOP_SQRT;
				areq.opa   = dcs_pkg::ARG_W'(sum_q);
			end
			S_G_GO: begin
				areq.start = 1'b1;
				areq.op    = dcs_pkg::AOP_DIV;
				areq.opa   = dcs_pkg::ARG_W'({dmag_q[ax_q], 16'b0});
				areq.opb   = dcs_pkg::MUL_B_W'(len_q);
			end
			S_LM_GO: begin
				areq.start = 1'b1;
				areq.op    = dcs_pkg::AOP_DIV;
				areq.opa   = dcs_pkg::ARG_W'({c_mag, 16'b0});
				areq.opb   = dcs_pkg::MUL_B_W'(k_w);
			end
			S_T_GO: begin
				areq.start = 1'b1;
				areq.op    = dcs_pkg::AOP_MUL;
				areq.opa   = dcs_pkg::ARG_W'(lm_q);
				case (term_q)
					2'd0:    areq.opb = dcs_pkg::MUL_B_W'(pa_q.inv_mass);
					2'd1:    areq.opb = dcs_pkg::MUL_B_W'(pb_q.inv_mass);
					default: areq.opb = inv_dt_sq_q;
				endcase
			end
			S_S_GO: begin
				areq.start = 1'b1;
				areq.op    = dcs_pkg::AOP_MUL;
				areq.opa   = dcs_pkg::ARG_W'(tmag_q[term_q]);
				areq.opb   = dcs_pkg::MUL_B_W'(gmag_q[ax_q]);
			end
			default: begin
				areq.start = 1'b0;
			end
		endcase
	end

	dcs_arith u_arith (
		.clk    (clk),
		.arst_n (arst_n),
		.req    (areq),
		.rsp    (arsp)
	);

	// Sequencer
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q       <= S_CLEAR;
			clr_cnt_q     <= '0;
			ax_q          <= '0;
			term_q        <= '0;
			pend_status_q <= dcs_pkg::STS_READ;
		end else begin
			case (state_q)
				S_CLEAR: begin
					if (clr_cnt_q == AW'(dcs_pkg::PARTICLES - 1)) begin
						state_q <= S_IDLE;
					end
					clr_cnt_q <= clr_cnt_q + 1'b1;
				end
				S_IDLE: begin
					if (accept) begin
						case (dcs_pkg::func_t'(cmd.func))
							dcs_pkg::FN_WRITE: state_q <= S_WRITE;
							dcs_pkg::FN_READ:  state_q <= S_RD_A;
							dcs_pkg::FN_CLEAR: begin
								clr_cnt_q <= '0;
								state_q   <= S_CLEAR;
							end
							default: begin
								if (a_in_ok && b_in_ok) begin
									state_q <= S_LD_A;
								end else begin
									pend_status_q <= dcs_pkg::STS_SKIPPED;
									state_q       <= S_OUT;
								end
							end
						endcase
					end
				end
				S_WRITE:  state_q <= S_IDLE;
				S_RD_A:   state_q <= S_RD_CAP;
				S_RD_CAP: begin
					pend_status_q <= dcs_pkg::STS_READ;
					state_q       <= S_OUT;
				end
				S_LD_A:   state_q <= S_LD_B;
				S_LD_B:   state_q <= S_CHK;
				S_CHK: begin
					if ({1'b0, pa_q.inv_mass} + {1'b0, pos_rd_q.inv_mass} == '0) begin
						pend_status_q <= dcs_pkg::STS_SKIPPED;
						state_q       <= S_OUT;
					end else begin
						state_q <= S_DIFF;
					end
				end
				S_DIFF: begin
					ax_q    <= '0;
					state_q <= S_SQ_GO;
				end
				S_SQ_GO:  state_q <= S_SQ_WAIT;
				S_SQ_WAIT: begin
					if (arsp.done) begin
						if (ax_q == 2'd2) begin
							ax_q    <= '0;
							state_q <= S_SQRT_GO;
						end else begin
							ax_q    <= ax_q + 1'b1;
							state_q <= S_SQ_GO;
						end
					end
				end
				S_SQRT_GO: state_q <= S_SQRT_WAIT;
				S_SQRT_WAIT: begin
					if (arsp.done) begin
						if (arsp.res[dcs_pkg::ROOT_W-1:0] == '0) begin
							pend_status_q <= dcs_pkg::STS_SKIPPED;
							state_q       <= S_OUT;
						end else begin
							state_q <= S_G_GO;
						end
					end
				end
				S_G_GO: state_q <= S_G_WAIT;
				S_G_WAIT: begin
					if (arsp.done) begin
						if (ax_q == 2'd2) begin
							ax_q    <= '0;
							state_q <= S_LM_GO;
						end else begin
							ax_q    <= ax_q + 1'b1;
							state_q <= S_G_GO;
						end
					end
				end
				S_LM_GO: state_q <= S_LM_WAIT;
				S_LM_WAIT: begin
					if (arsp.done) begin
						term_q  <= '0;
						state_q <= S_T_GO;
					end
				end
				S_T_GO: state_q <= S_T_WAIT;
				S_T_WAIT: begin
					if (arsp.done) begin
						if (term_q == 2'd2) begin
							term_q  <= '0;
							ax_q    <= '0;
							state_q <= S_S_GO;
						end else begin
							term_q  <= term_q + 1'b1;
							state_q <= S_T_GO;
						end
					end
				end
				S_S_GO: state_q <= S_S_WAIT;
				S_S_WAIT: begin
					if (arsp.done) begin
						if (term_q == 2'd2 || (term_q == 2'd1 && kind_q)) begin
							term_q <= '0;
							if (ax_q == 2'd2) begin
								ax_q    <= '0;
								state_q <= S_WB_A;
							end else begin
								ax_q    <= ax_q + 1'b1;
								state_q <= S_S_GO;
							end
						end else begin
							term_q  <= term_q + 1'b1;
							state_q <= S_S_GO;
						end
					end
				end
				S_WB_A: state_q <= S_WB_B;
				S_WB_B: begin
					pend_status_q <= dcs_pkg::STS_APPLIED;
					state_q       <= S_OUT;
				end
				S_OUT: begin
					if (out_free) begin
						state_q <= S_IDLE;
					end
				end
				default: state_q <= S_IDLE;
			endcase
		end
	end

	// Item capture and solve datapath
	always_ff @(posedge clk) begin
		if (accept) begin
			func_q          <= dcs_pkg::func_t'(cmd.func);
			kind_q          <= cmd.kind;
			a_q             <= AW'(cmd.particle_a);
			b_q             <= AW'(cmd.particle_b);
			a_ok_q          <= a_in_ok;
			rest_q          <= cmd.rest_length;
			wdat_q.pos[0]   <= cmd.pos_x;
			wdat_q.pos[1]   <= cmd.pos_y;
			wdat_q.pos[2]   <= cmd.pos_z;
			wdat_q.inv_mass <= cmd.inv_mass;
		end
		case (state_q)
			S_RD_CAP: begin
				pa_q <= a_ok_q ? pos_rd_q : '0;
				fa_q <= a_ok_q ? frc_rd_q : '0;
			end
			S_LD_B: begin
				pa_q <= pos_rd_q;
				fa_q <= frc_rd_q;
			end
			S_CHK: begin
				pb_q <= pos_rd_q;
				fb_q <= frc_rd_q;
			end
			S_DIFF: begin
				for (int i = 0; i < 3; i++) begin
					logic [32:0] dw;
					dw = {pa_q.pos[i][31], pa_q.pos[i]} - {pb_q.pos[i][31], pb_q.pos[i]};
					dneg_q[i] <= dw[32];
					dmag_q[i] <= dw[32] ? 33'(-dw) : dw;
				end
				sum_q <= '0;
			end
			S_SQ_WAIT: begin
				if (arsp.done) begin
					sum_q <= sum_q + arsp.res[65:0];
				end
			end
			S_SQRT_WAIT: begin
				len_q <= arsp.res[dcs_pkg::ROOT_W-1:0];
			end
			S_G_WAIT: begin
				gmag_q[ax_q] <= arsp.res[16:0];
				gneg_q[ax_q] <= dneg_q[ax_q];
			end
			S_LM_WAIT: begin
				lm_q      <= arsp.res[dcs_pkg::MUL_A_W-1:0];
				lam_neg_q <= !c_w[34] && (c_w != '0);
			end
			S_T_WAIT: begin
				tmag_q[term_q] <= (t_raw > 83'(t_lim)) ? t_lim : t_raw[46:0];
			end
			S_S_WAIT: begin
				if (arsp.done) begin
					case (term_q)
						2'd0: pa_q.pos[ax_q] <= sat32(pos_sum);
						2'd1: pb_q.pos[ax_q] <= sat32(pos_sum);
						default: begin
							fa_q[ax_q] <= sat48(frc_sum_a);
							fb_q[ax_q] <= sat48(frc_sum_b);
						end
					endcase
				end
			end
			default: begin
				len_q <= len_q;
			end
		endcase
	end

	// Output register: hold the result until the transfer completes
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			ovalid_q <= 1'b0;
		end else if (state_q == S_OUT && out_free) begin
			ovalid_q <= 1'b1;
		end else if (rsp.ready) begin
			ovalid_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (state_q == S_OUT && out_free) begin
			ostatus_q <= pend_status_q;
			if (func_q == dcs_pkg::FN_READ) begin
				opart_q <= pa_q;
				ofrc_q  <= fa_q;
			end else begin
				opart_q <= '0;
				ofrc_q  <= '0;
			end
		end
	end

endmodule

// ===== hw/rtl/dcs_checker.sv =====
// Port-level checks of the distance constraint solver, bound to its top level.
// Depends on dcs_pkg and on the ports of distance_constraint_solver_top.

module dcs_checker (
	input logic                          clk,
	input logic                          arst_n,
	input logic                          cmd_valid,
	input logic                          cmd_ready,
	input logic [1:0]                    cmd_func,
	input logic                          rsp_valid,
	input logic                          rsp_ready,
	input logic [1:0]                    rsp_status,
	input logic [dcs_pkg::POS_W-1:0]     rsp_pos_x,
	input logic [dcs_pkg::FRC_W-1:0]     rsp_force_x,
	input logic [dcs_pkg::MASS_W-1:0]    rsp_inv_mass
);

	// A pending result stays until its transfer
	a_rsp_hold: assert property (@(posedge clk) disable iff (!arst_n)
		rsp_valid && !rsp_ready |=> rsp_valid)
		else $error("result dropped before transfer");

	// A stalled result keeps its status
	a_rsp_stable: assert property (@(posedge clk) disable iff (!arst_n)
		rsp_valid && !rsp_ready |=> $stable(rsp_status))
		else $error("result status changed while stalled");

	// One item at a time: no second transfer right after a solve or read is taken
	a_one_item: assert property (@(posedge clk) disable iff (!arst_n)
		cmd_valid && cmd_ready && (cmd_func == dcs_pkg::FN_SOLVE
			|| cmd_func == dcs_pkg::FN_READ) |=> !cmd_ready)
		else $error("new item taken while a solve or read is in progress");

	// Solve results carry status only
	a_solve_zero: assert property (@(posedge clk) disable iff (!arst_n)
		rsp_valid && rsp_status != dcs_pkg::STS_READ |->
			rsp_pos_x == '0 && rsp_force_x == '0 && rsp_inv_mass == '0)
		else $error("solve result carries data");

	// Status is one of the defined codes
	a_status_code: assert property (@(posedge clk) disable iff (!arst_n)
		rsp_valid |-> rsp_status == dcs_pkg::STS_READ
			|| rsp_status == dcs_pkg::STS_APPLIED || rsp_status == dcs_pkg::STS_SKIPPED)
		else $error("undefined result status");

endmodule

bind distance_constraint_solver_top dcs_checker u_dcs_checker (
	.clk          (clk),
	.arst_n       (arst_n),
	.cmd_valid    (cmd.valid),
	.cmd_ready    (cmd.ready),
	.cmd_func     (cmd.func),
	.rsp_valid    (rsp.valid),
	.rsp_ready    (rsp.ready),
	.rsp_status   (rsp.status),
	.rsp_pos_x    (rsp.out_pos_x),
	.rsp_force_x  (rsp.out_force_x),
	.rsp_inv_mass (rsp.out_inv_mass)
);

// ===== test/distance_constraint_solver_top_test.sv =====
// Testbench of the distance constraint solver: directed and random items, with a
// bit-accurate fixed-point predictor. Depends on dcs_pkg, dcs_if and the top level.
`timescale 1ns / 100ps

module distance_constraint_solver_top_test;

	localparam int CYCLE_LIMIT   = 1500000;
	localparam int SETTLE_CYCLES = dcs_pkg::PARTICLES + 100;
	localparam int EXP_DEPTH     = 1024;

	typedef struct {
		dcs_pkg::func_t fn;
		logic        kind;
		logic [9:0]  a;
		logic [9:0]  b;
		logic [30:0] rest;
		logic [31:0] px;
		logic [31:0] py;
		logic [31:0] pz;
		logic [31:0] m;
	} item_t;

	// status, pos x/y/z, force x/y/z, inverse mass
	typedef logic [7:0][63:0] result_t;

	logic clk = 1'b0;
	logic arst_n;
	logic cfg_wr_en;
	logic [dcs_pkg::CFG_IDX_W-1:0] cfg_index;
	logic [dcs_pkg::CFG_W-1:0] cfg_wdata;

	dcs_cmd_if cmd_ch ();
	dcs_rsp_if rsp_ch ();

	distance_constraint_solver_top u_dut (
		.clk(clk),
		.arst_n(arst_n),
		.cmd(cmd_ch),
		.rsp(rsp_ch),
		.cfg_wr_en(cfg_wr_en),
		.cfg_index(cfg_index),
		.cfg_wdata(cfg_wdata)
	);

	// Predictor state
	longint      pos_mem [dcs_pkg::PARTICLES][3];
	longint      frc_mem [dcs_pkg::PARTICLES][3];
	logic [31:0] mass_mem [dcs_pkg::PARTICLES];
	int          written_list [dcs_pkg::PARTICLES];
	int          written_cnt;
	bit          written [dcs_pkg::PARTICLES];
	logic [31:0] stretch_alpha_r;
	logic [31:0] bend_alpha_r;
	logic [47:0] inv_dt_sq_r;

	// expected results, oldest at exp_rd
	result_t exp_mem [EXP_DEPTH];
	int      exp_wr;
	int      exp_rd;
	result_t got_r;
	result_t want_r;
	int      errors;
	int      cycles;
	int      burst_left;
	int      stall_left;
	int      stall_mode;
	string   field_names [8] = '{"status", "pos_x", "pos_y", "pos_z",
		"force_x", "force_y", "force_z", "inv_mass"};

	always begin
		#1 clk = 1'b1;
		#1 clk = 1'b0;
	end

	// Fixed-point helpers
	function automatic logic [63:0] mag(longint v);
		return (v < 0) ? 64'(-v) : 64'(v);
	endfunction

	function automatic longint clip(longint v, longint lo, longint hi);
		return (v < lo) ? lo : ((v > hi) ? hi : v);
	endfunction

	function automatic longint scaled_mul(longint x, longint y, logic [63:0] lim);
		logic [127:0] p;
		logic [63:0]  r;
		p = ({64'd0, mag(x)} * {64'd0, mag(y)}) >> 16;
		r = (p > {64'd0, lim}) ? lim : p[63:0];
		return ((x < 0) != (y < 0)) ? -longint'(r) : longint'(r);
	endfunction

	function automatic logic [63:0] root_floor(logic [127:0] n);
		logic [63:0] r;
		logic [63:0] t;
		r = 0;
		for (int s = 33; s >= 0; s--) begin
			t = r | (64'd1 << s);
			if ({64'd0, t} * {64'd0, t} <= n) r = t;
		end
		return r;
	endfunction

	function automatic dcs_pkg::status_t project_constraint(int a, int b, logic bend,
			logic [30:0] rest);
		logic [63:0]  w0;
		logic [63:0]  w1;
		logic [63:0]  k;
		logic [63:0]  len;
		logic [63:0]  lm;
		logic [63:0]  q;
		logic [127:0] sq;
		longint d [3];
		longint g [3];
		longint c;
		longint lambda;
		longint t0;
		longint t1;
		longint f;
		longint df;
		w0 = {32'd0, mass_mem[a]};
		w1 = {32'd0, mass_mem[b]};
		if (w0 + w1 == 0) return dcs_pkg::STS_SKIPPED;
		sq = 0;
		for (int i = 0; i < 3; i++) begin
			d[i] = pos_mem[a][i] - pos_mem[b][i];
			sq += {64'd0, mag(d[i])} * {64'd0, mag(d[i])};
		end
		len = root_floor(sq);
		if (len == 0) return dcs_pkg::STS_SKIPPED;
		for (int i = 0; i < 3; i++) begin
			q = (mag(d[i]) << 16) / len;
			g[i] = (d[i] < 0) ? -longint'(q) : longint'(q);
		end
		k = w0 + w1 + {32'd0, bend ? bend_alpha_r : stretch_alpha_r};
		c = longint'(len) - longint'({33'd0, rest});
		lm = (mag(c) << 16) / k;
		lambda = (c > 0) ? -longint'(lm) : longint'(lm);
		t0 = scaled_mul(lambda, longint'(w0), 64'(dcs_pkg::T_LIM));
		t1 = scaled_mul(lambda, longint'(w1), 64'(dcs_pkg::T_LIM));
		f = scaled_mul(lambda, longint'({16'd0, inv_dt_sq_r}), 64'(dcs_pkg::F_LIM));
		for (int i = 0; i < 3; i++) begin
			pos_mem[a][i] = clip(pos_mem[a][i]
				+ scaled_mul(t0, g[i], 64'(dcs_pkg::T_LIM)),
				-64'sd2147483648, 64'sd2147483647);
			pos_mem[b][i] = clip(pos_mem[b][i]
				- scaled_mul(t1, g[i], 64'(dcs_pkg::T_LIM)),
				-64'sd2147483648, 64'sd2147483647);
			if (!bend) begin
				df = scaled_mul(f, g[i], 64'(dcs_pkg::F_LIM));
				frc_mem[a][i] = clip(frc_mem[a][i] + df, -64'sd140737488355328,
					64'sd140737488355327);
				frc_mem[b][i] = clip(frc_mem[b][i] - df, -64'sd140737488355328,
					64'sd140737488355327);
			end
		end
		return dcs_pkg::STS_APPLIED;
	endfunction

	// Append one expectation
	function automatic void expect_result(result_t r);
		exp_mem[exp_wr % EXP_DEPTH] = r;
		exp_wr++;
	endfunction

	// Update the model on an accepted item and queue its result, if any
	function automatic void predict_item(item_t it);
		result_t r;
		r = '0;
		case (it.fn)
			dcs_pkg::FN_WRITE: begin
				pos_mem[it.a][0] = longint'(signed'(it.px));
				pos_mem[it.a][1] = longint'(signed'(it.py));
				pos_mem[it.a][2] = longint'(signed'(it.pz));
				mass_mem[it.a] = it.m;
				if (!written[it.a]) begin
					written[it.a] = 1'b1;
					written_list[written_cnt] = int'(it.a);
					written_cnt++;
				end
			end
			dcs_pkg::FN_CLEAR: begin
				for (int p = 0; p < dcs_pkg::PARTICLES; p++)
					for (int i = 0; i < 3; i++) frc_mem[p][i] = 0;
			end
			dcs_pkg::FN_READ: begin
				r[0] = 64'(dcs_pkg::STS_READ);
				for (int i = 0; i < 3; i++) begin
					r[1 + i] = {32'd0, pos_mem[it.a][i][31:0]};
					r[4 + i] = {16'd0, frc_mem[it.a][i][47:0]};
				end
				r[7] = {32'd0, mass_mem[it.a]};
				expect_result(r);
			end
			default: begin
				r[0] = 64'(project_constraint(int'(it.a), int'(it.b), it.kind, it.rest));
				expect_result(r);
			end
		endcase
	endfunction

	function automatic item_t mk(dcs_pkg::func_t fn, int kind, int a, int b, longint rest,
			longint px, longint py, longint pz, longint m);
		item_t it;
		it.fn = fn;
		it.kind = 1'(kind);
		it.a = 10'(a);
		it.b = 10'(b);
		it.rest = 31'(rest);
		it.px = 32'(px);
		it.py = 32'(py);
		it.pz = 32'(pz);
		it.m = 32'(m);
		return it;
	endfunction

	function automatic logic [31:0] rand_pos();
		if ($urandom_range(0, 4) == 0) return $urandom;
		return 32'($urandom_range(0, 1 << 21)) - 32'(1 << 20);
	endfunction

	// Mostly well-formed traffic on a small pool of particles, some on any index
	function automatic item_t rand_item();
		item_t it;
		int sel;
		int n;
		it = mk(dcs_pkg::FN_WRITE, int'($urandom_range(0, 1)), 0, 0, longint'($urandom),
			longint'($urandom), longint'($urandom), longint'($urandom), longint'($urandom));
		sel = $urandom_range(0, 99);
		n = written_cnt;
		if (sel < 25 || n == 0) begin
			it.a = ($urandom_range(0, 6) == 0) ? 10'($urandom) : 10'($urandom_range(0, 15));
			it.px = rand_pos();
			it.py = rand_pos();
			it.pz = rand_pos();
			sel = $urandom_range(0, 9);
			it.m = (sel == 0) ? 32'd0 : ((sel == 1) ? $urandom : 32'($urandom_range(1, 1 << 18)));
		end else if (sel < 95) begin
			it.fn = (sel < 75) ? dcs_pkg::FN_SOLVE : dcs_pkg::FN_READ;
			it.a = 10'(written_list[$urandom_range(0, n - 1)]);
			it.b = ($urandom_range(0, 19) == 0) ? it.a
				: 10'(written_list[$urandom_range(0, n - 1)]);
			if ($urandom_range(0, 1) == 0) it.rest = 31'($urandom_range(0, 1 << 21));
		end else begin
			it.fn = dcs_pkg::FN_CLEAR;
		end
		return it;
	endfunction

	// Present one item in bursts with random gaps, hold until the transfer
	task automatic send_item(item_t it);
		int gap;
		if (burst_left == 0) begin
			gap = $urandom_range(0, 12);
			burst_left = $urandom_range(1, 20);
			if (gap > 0) begin
				cmd_ch.valid <= 1'b0;
				repeat (gap) @(posedge clk);
			end
		end
		burst_left--;
		cmd_ch.valid <= 1'b1;
		cmd_ch.func <= it.fn;
		cmd_ch.kind <= it.kind;
		cmd_ch.particle_a <= it.a;
		cmd_ch.particle_b <= it.b;
		cmd_ch.rest_length <= it.rest;
		cmd_ch.pos_x <= it.px;
		cmd_ch.pos_y <= it.py;
		cmd_ch.pos_z <= it.pz;
		cmd_ch.inv_mass <= it.m;
		do @(posedge clk); while (!cmd_ch.ready);
		predict_item(it);
	endtask

	// Drop valid and wait for every queued result
	task automatic drain_results();
		cmd_ch.valid <= 1'b0;
		burst_left = 0;
		while (exp_wr != exp_rd) @(posedge clk);
	endtask

	// Write all registers while the block is idle
	task automatic write_config(logic [31:0] sa, logic [31:0] ba, logic [47:0] idt);
		drain_results();
		repeat (SETTLE_CYCLES) @(posedge clk);
		cfg_wr_en <= 1'b1;
		cfg_index <= dcs_pkg::REG_STRETCH_ALPHA;
		cfg_wdata <= {16'd0, sa};
		@(posedge clk);
		cfg_index <= dcs_pkg::REG_BEND_ALPHA;
		cfg_wdata <= {16'd0, ba};
		@(posedge clk);
		cfg_index <= dcs_pkg::REG_INV_DT_SQ;
		cfg_wdata <= idt;
		@(posedge clk);
		cfg_wr_en <= 1'b0;
		stretch_alpha_r = sa;
		bend_alpha_r = ba;
		inv_dt_sq_r = idt;
	endtask

	task automatic test_directed_store();
		send_item(mk(dcs_pkg::FN_WRITE, 0, 0, 0, 0, 32'h8000_0000, 32'h8000_0000,
			32'h8000_0000, 32'hFFFF_FFFF));
		send_item(mk(dcs_pkg::FN_WRITE, 1, 1, 0, 0, 32'h7FFF_FFFF, 32'h7FFF_FFFF,
			32'h7FFF_FFFF, 32'hFFFF_FFFF));
		send_item(mk(dcs_pkg::FN_WRITE, 0, 2, 0, 0, 0, 0, 0, 0));
		send_item(mk(dcs_pkg::FN_WRITE, 0, 3, 0, 0, 32'h1_0000, 0, 0, 0));
		send_item(mk(dcs_pkg::FN_WRITE, 0, 4, 0, 0, 32'h5_0000, 32'h5_0000, 32'h5_0000,
			32'h1_0000));
		send_item(mk(dcs_pkg::FN_WRITE, 0, 5, 0, 0, 32'h5_0000, 32'h5_0000, 32'h5_0000,
			32'h1_0000));
		send_item(mk(dcs_pkg::FN_WRITE, 0, 1023, 1023, 31'h7FFF_FFFF, 32'hFFFD_0000,
			32'h2_0000, 32'h8000, 32'h1_0000));
		send_item(mk(dcs_pkg::FN_READ, 0, 1023, 0, 0, 0, 0, 0, 0));
		send_item(mk(dcs_pkg::FN_READ, 0, 0, 0, 0, 0, 0, 0, 0));
	endtask

	task automatic test_directed_solve();
		// both particles fixed, coincident particles, and one particle with itself
		send_item(mk(dcs_pkg::FN_SOLVE, 0, 2, 3, 0, 0, 0, 0, 0));
		send_item(mk(dcs_pkg::FN_SOLVE, 0, 4, 5, 0, 0, 0, 0, 0));
		send_item(mk(dcs_pkg::FN_SOLVE, 1, 4, 4, 0, 0, 0, 0, 0));
		send_item(mk(dcs_pkg::FN_SOLVE, 0, 0, 1, 0, 0, 0, 0, 0));
		send_item(mk(dcs_pkg::FN_READ, 0, 0, 0, 0, 0, 0, 0, 0));
		send_item(mk(dcs_pkg::FN_READ, 0, 1, 0, 0, 0, 0, 0, 0));
		send_item(mk(dcs_pkg::FN_SOLVE, 1, 0, 1, 31'h7FFF_FFFF, 0, 0, 0, 0));
		send_item(mk(dcs_pkg::FN_READ, 0, 0, 0, 0, 0, 0, 0, 0));
		send_item(mk(dcs_pkg::FN_SOLVE, 0, 1023, 4, 31'h1_0000, 0, 0, 0, 0));
		send_item(mk(dcs_pkg::FN_READ, 0, 1023, 0, 0, 0, 0, 0, 0));
		send_item(mk(dcs_pkg::FN_READ, 0, 4, 0, 0, 0, 0, 0, 0));
		send_item(mk(dcs_pkg::FN_CLEAR, 0, 0, 0, 0, 0, 0, 0, 0));
		send_item(mk(dcs_pkg::FN_READ, 0, 1023, 0, 0, 0, 0, 0, 0));
		send_item(mk(dcs_pkg::FN_SOLVE, 0, 3, 1023, 31'h2_0000, 0, 0, 0, 0));
		send_item(mk(dcs_pkg::FN_READ, 0, 3, 0, 0, 0, 0, 0, 0));
	endtask

	task automatic test_random_phase(int count);
		repeat (count) send_item(rand_item());
	endtask

	// Hold the sender mid-stream until every result is back
	task automatic test_pause_until_empty();
		test_random_phase(20);
		drain_results();
		test_random_phase(20);
	endtask

	// Receiver stall pattern: stretches of always ready, random and mostly stalled
	always @(posedge clk) begin
		if (stall_left == 0) begin
			stall_mode <= $urandom_range(0, 2);
			stall_left <= $urandom_range(1, 200);
		end else begin
			stall_left <= stall_left - 1;
		end
		case (stall_mode)
			0: rsp_ch.ready <= 1'b1;
			1: rsp_ch.ready <= 1'($urandom);
			default: rsp_ch.ready <= ($urandom_range(0, 3) == 0);
		endcase
	end

	// Compare each result transfer with the oldest expectation
	always @(posedge clk) begin
		if (arst_n && rsp_ch.valid && rsp_ch.ready) begin
			got_r[0] = 64'(rsp_ch.status);
			got_r[1] = {32'd0, rsp_ch.out_pos_x};
			got_r[2] = {32'd0, rsp_ch.out_pos_y};
			got_r[3] = {32'd0, rsp_ch.out_pos_z};
			got_r[4] = {16'd0, rsp_ch.out_force_x};
			got_r[5] = {16'd0, rsp_ch.out_force_y};
			got_r[6] = {16'd0, rsp_ch.out_force_z};
			got_r[7] = {32'd0, rsp_ch.out_inv_mass};
			if (exp_wr == exp_rd) begin
				$display("%0t: result with none expected, status %h", $time, got_r[0]);
				errors++;
			end else begin
				want_r = exp_mem[exp_rd % EXP_DEPTH];
				exp_rd++;
				for (int i = 0; i < 8; i++) begin
					if (want_r[i] !== got_r[i]) begin
						$display("%0t: %s expected %h actual %h", $time, field_names[i],
							want_r[i], got_r[i]);
						errors++;
					end
				end
			end
		end
	end

	// End the run at the cycle limit
	always @(posedge clk) begin
		cycles <= cycles + 1;
		if (cycles >= CYCLE_LIMIT) begin
			$display("CHECK FAILED");
			$finish;
		end
	end

	initial begin
		arst_n <= 1'b0;
		cfg_wr_en <= 1'b0;
		cfg_index <= dcs_pkg::REG_STRETCH_ALPHA;
		cfg_wdata <= '0;
		cmd_ch.valid <= 1'b0;
		cmd_ch.func <= dcs_pkg::FN_WRITE;
		cmd_ch.kind <= 1'b0;
		cmd_ch.particle_a <= '0;
		cmd_ch.particle_b <= '0;
		cmd_ch.rest_length <= '0;
		cmd_ch.pos_x <= '0;
		cmd_ch.pos_y <= '0;
		cmd_ch.pos_z <= '0;
		cmd_ch.inv_mass <= '0;
		burst_left = 0;
		written_cnt = 0;
		exp_wr = 0;
		stretch_alpha_r = 32'd0;
		bend_alpha_r = 32'd0;
		inv_dt_sq_r = dcs_pkg::INV_DT_SQ_RST;
		for (int p = 0; p < dcs_pkg::PARTICLES; p++) begin
			mass_mem[p] = 0;
			written[p] = 1'b0;
			for (int i = 0; i < 3; i++) begin
				pos_mem[p][i] = 0;
				frc_mem[p][i] = 0;
			end
		end
		repeat (11) @(posedge clk);
		arst_n <= 1'b1;

		test_directed_store();
		test_directed_solve();
		write_config($urandom, $urandom, {16'($urandom), 32'($urandom)});
		test_random_phase(130);
		test_pause_until_empty();
		write_config(32'hFFFF_FFFF, 32'hFFFF_FFFF, 48'hFFFF_FFFF_FFFF);
		test_random_phase(120);
		write_config(32'h1_0000, 32'h8000, 48'd0);
		test_random_phase(120);
		write_config(32'd0, 32'd0, dcs_pkg::INV_DT_SQ_RST);
		test_random_phase(120);

		drain_results();
		repeat (SETTLE_CYCLES) @(posedge clk);
		if (errors == 0 && exp_wr == exp_rd) begin
			$display("CHECK OK");
		end else begin
			$display("CHECK FAILED");
		end
		$finish;
	end

endmodule

// ===== filelist.f =====
hw/rtl/dcs_pkg.sv
hw/rtl/dcs_if.sv
hw/rtl/dcs_arith.sv
hw/rtl/distance_constraint_solver_top.sv
hw/rtl/dcs_checker.sv
test/distance_constraint_solver_top_test.sv
